/* rtl/core/hrfs_pkg.sv */
// Shared types, widths and constants for the rod heat-step block.
`timescale 1ns / 1ps
package hrfs_pkg;

	localparam int unsigned TEMP_W       = 32;
	localparam int unsigned R_W          = 16;
	localparam int unsigned NC_W         = 10;
	localparam int unsigned IDX_W        = 9;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned STEPS_W      = 32;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 32;
	localparam int unsigned MAX_NODES_DEF = 512;
	localparam int unsigned NC_MIN       = 3;
	localparam int unsigned QDEPTH       = 2;
	localparam int unsigned QAW          = $clog2(QDEPTH);

	localparam logic [R_W-1:0]    R_MAX       = 16'd32768;
	localparam logic [R_W-1:0]    FOURIER_RST = 16'd31588;
	localparam logic [TEMP_W-1:0] SOURCE_RST  = 32'd32768000;
	localparam logic [TEMP_W-1:0] AMBIENT_RST = 32'd19660800;
	localparam logic [NC_W-1:0]   NCOUNT_RST  = 10'd501;

	typedef enum logic [OP_W-1:0] {
		OP_INIT = 2'd0,
		OP_STEP = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOURIER = 2'd0,
		REG_SOURCE  = 2'd1,
		REG_AMBIENT = 2'd2,
		REG_NCOUNT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic             idx_err;
	} job_t;

	typedef struct packed {
		logic [R_W-1:0]    r;
		logic [TEMP_W-1:0] source;
		logic [TEMP_W-1:0] ambient;
	} cfg_view_t;

	typedef struct packed {
		logic [TEMP_W-1:0]  temperature;
		logic               index_error;
		logic [STEPS_W-1:0] steps_done;
	} result_t;

endpackage

/* rtl/core/hrfs_if.sv */
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps
interface hrfs_req_if;
	logic                       valid;
	logic                       ready;
	logic [hrfs_pkg::OP_W-1:0]  operation;
	logic [hrfs_pkg::IDX_W-1:0] node_index;
	modport source(output valid, operation, node_index, input ready);
	modport sink(input valid, operation, node_index, output ready);
endinterface

interface hrfs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [hrfs_pkg::TEMP_W-1:0]  temperature;
	logic                         index_error;
	logic [hrfs_pkg::STEPS_W-1:0] steps_done;
	modport source(output valid, temperature, index_error, steps_done, input ready);
	modport sink(input valid, temperature, index_error, steps_done, output ready);
endinterface

interface hrfs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [hrfs_pkg::CFG_IDX_W-1:0]  index;
	logic [hrfs_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/hrfs_front.sv */
// Front end: accepts request transactions and decodes them into jobs.
`timescale 1ns / 1ps
module hrfs_front #(
	parameter int unsigned MAX_NODES = hrfs_pkg::MAX_NODES_DEF,
	localparam int unsigned CW = $clog2(MAX_NODES + 1)
) (
	hrfs_req_if.sink          req,
	input  logic [CW-1:0]     n_use,
	input  logic              clearing,
	output logic              push_valid,
	input  logic              push_ready,
	output hrfs_pkg::job_t    push_data
);
	import hrfs_pkg::*;

	op_t op;

	assign op         = op_t'(req.operation);
	assign req.ready  = push_ready & ~clearing;
	assign push_valid = req.valid & ~clearing;

	always_comb begin
		push_data.op      = op;
		push_data.idx     = req.node_index;
		push_data.idx_err = (op == OP_READ) && (32'(req.node_index) >= 32'(n_use));
	end

endmodule

/* rtl/core/hrfs_queue.sv */
// Short job queue between the front end and the execution engine.
`timescale 1ns / 1ps
module hrfs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  hrfs_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output hrfs_pkg::job_t pop_data
);
	import hrfs_pkg::*;

	job_t             entries_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QAW:0]     cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = entries_q[rd_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/hrfs_back.sv */
// Execution engine: node memory, stencil sweep, fill, read and result register.
`timescale 1ns / 1ps
module hrfs_back #(
	parameter int unsigned MAX_NODES = hrfs_pkg::MAX_NODES_DEF,
	localparam int unsigned AW = $clog2(MAX_NODES),
	localparam int unsigned CW = $clog2(MAX_NODES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hrfs_pkg::cfg_view_t cfgv,
	input  logic [CW-1:0]       n_use,
	output logic                clearing,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  hrfs_pkg::job_t      pop_data,
	hrfs_rsp_if.source          rsp
);
	import hrfs_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_STEP,
		ST_EDGE_L,
		ST_EDGE_R,
		ST_READ,
		ST_RD_DATA,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      ptr_q;
	job_t               job_q;
	result_t            res_q;
	logic [STEPS_W-1:0] steps_q;

	logic [TEMP_W-1:0]  mem [MAX_NODES];
	logic [TEMP_W-1:0]  mem_rd_q;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [TEMP_W-1:0]  wdata;
	logic [AW-1:0]      raddr;
	logic               rd_issue;
	logic               drained;
	logic [AW-1:0]      n_last;

	logic               v_s1;
	logic [CW-1:0]      k_s1;
	logic               v_s2;
	logic [AW-1:0]      j_s2;
	logic [TEMP_W-1:0]  prv_s2;
	logic [TEMP_W-1:0]  cur_s2;
	logic [TEMP_W-1:0]  nxt_s2;
	logic               v_s3;
	logic [AW-1:0]      j_s3;
	logic [TEMP_W-1:0]  cur_s3;
	logic signed [33:0] lap_s3;
	logic               v_s4;
	logic [AW-1:0]      j_s4;
	logic [TEMP_W-1:0]  cur_s4;
	logic signed [48:0] prod_s4;

	logic signed [33:0] lap_d;
	logic signed [48:0] prod_d;
	logic signed [34:0] sum_d;
	logic [TEMP_W-1:0]  new_d;

	assign clearing  = (state_q == ST_CLEAR);
	assign pop_ready = (state_q == ST_IDLE);
	assign rsp.valid       = (state_q == ST_DONE);
	assign rsp.temperature = res_q.temperature;
	assign rsp.index_error = res_q.index_error;
	assign rsp.steps_done  = res_q.steps_done;

	assign n_last   = AW'(n_use - 1'b1);
	assign rd_issue = (state_q == ST_STEP) && (ptr_q < n_use);
	assign drained  = (ptr_q == n_use) && !v_s1 && !v_s2 && !v_s3 && !v_s4;

	// stencil datapath
	assign lap_d  = $signed({2'b00, nxt_s2}) + $signed({2'b00, prv_s2})
	              - $signed({1'b0, cur_s2, 1'b0});
	assign prod_d = lap_s3 * $signed({1'b0, cfgv.r});
	assign sum_d  = $signed({3'b000, cur_s4}) + 35'(prod_s4 >>> 16);

	always_comb begin
		if (sum_d < 0) begin
			new_d = '0;
		end else if (sum_d[33:32] != 2'b00) begin
			new_d = '1;
		end else begin
			new_d = sum_d[31:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q[AW-1:0];
		wdata = '0;
		raddr = ptr_q[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_FILL: begin
				we    = 1'b1;
				wdata = (ptr_q == '0) ? cfgv.source : cfgv.ambient;
			end
			ST_STEP: begin
				we    = v_s4;
				waddr = j_s4;
				wdata = new_d;
			end
			ST_EDGE_L: begin
				we    = 1'b1;
				waddr = '0;
				wdata = cfgv.source;
			end
			ST_EDGE_R: begin
				we    = 1'b1;
				waddr = n_last;
				wdata = cfgv.ambient;
			end
			ST_READ: begin
				raddr = AW'(job_q.idx);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_rd_q <= mem[raddr];
	end

	// sweep pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_issue;
			v_s2 <= v_s1 && (k_s1 >= CW'(2));
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// sweep pipeline payload; the window holds old values of j-1, j, j+1
	always_ff @(posedge clk) begin
		k_s1 <= ptr_q;
		if (v_s1) begin
			prv_s2 <= cur_s2;
			cur_s2 <= nxt_s2;
			nxt_s2 <= mem_rd_q;
		end
		j_s2    <= AW'(k_s1 - 1'b1);
		lap_s3  <= lap_d;
		cur_s3  <= cur_s2;
		j_s3    <= j_s2;
		prod_s4 <= prod_d;
		cur_s4  <= cur_s3;
		j_s4    <= j_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
			job_q   <= '0;
			res_q   <= '0;
			steps_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == CW'(MAX_NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop_valid) begin
						job_q <= pop_data;
						ptr_q <= '0;
						case (pop_data.op)
							OP_INIT: state_q <= ST_FILL;
							OP_STEP: state_q <= ST_STEP;
							OP_READ: begin
								if (pop_data.idx_err) begin
									res_q   <= '{temperature: '0, index_error: 1'b1,
									             steps_done: steps_q};
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_READ;
								end
							end
							default: begin
								res_q   <= '{temperature: '0, index_error: 1'b0,
								             steps_done: steps_q};
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_FILL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == CW'(MAX_NODES - 1)) begin
						steps_q <= '0;
						res_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_STEP: begin
					if (rd_issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (drained) begin
						state_q <= ST_EDGE_L;
					end
				end
				ST_EDGE_L: begin
					state_q <= ST_EDGE_R;
				end
				ST_EDGE_R: begin
					steps_q <= (steps_q == '1) ? steps_q : steps_q + 1'b1;
					res_q   <= '{temperature: '0, index_error: 1'b0,
					             steps_done: (steps_q == '1) ? steps_q : steps_q + 1'b1};
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					res_q   <= '{temperature: mem_rd_q, index_error: 1'b0,
					             steps_done: steps_q};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/heat_rod_ftcs_step_top.sv */
// Top level of the rod heat-step block: configuration registers and core wiring.
// Throughput is one job at a time, set by the one-node-per-cycle sweep over node memory.
// The 2-entry job queue keeps accepting requests while a response waits, until it is full.
// After reset a clearing pass zeroes every node; req.ready is low until it ends.
`timescale 1ns / 1ps
module heat_rod_ftcs_step_top #(
	parameter int unsigned MAX_NODES = hrfs_pkg::MAX_NODES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	hrfs_req_if.sink    req,
	hrfs_rsp_if.source  rsp,
	hrfs_cfg_if.sink    cfg
);
	import hrfs_pkg::*;

	localparam int unsigned CW = $clog2(MAX_NODES + 1);

	logic [R_W-1:0]    fourier_q;
	logic [TEMP_W-1:0] source_q;
	logic [TEMP_W-1:0] ambient_q;
	logic [NC_W-1:0]   ncount_q;
	logic [CW-1:0]     n_use;
	cfg_view_t         cfgv;
	logic              clearing;
	logic              push_valid;
	logic              push_ready;
	job_t              push_data;
	logic              pop_valid;
	logic              pop_ready;
	job_t              pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fourier_q <= FOURIER_RST;
			source_q  <= SOURCE_RST;
			ambient_q <= AMBIENT_RST;
			ncount_q  <= NCOUNT_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_FOURIER: fourier_q <= cfg.data[R_W-1:0];
				REG_SOURCE:  source_q  <= cfg.data[TEMP_W-1:0];
				REG_AMBIENT: ambient_q <= cfg.data[TEMP_W-1:0];
				REG_NCOUNT:  ncount_q  <= cfg.data[NC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (32'(ncount_q) < 32'(NC_MIN)) begin
			n_use = CW'(NC_MIN);
		end else if (32'(ncount_q) > 32'(MAX_NODES)) begin
			n_use = CW'(MAX_NODES);
		end else begin
			n_use = CW'(ncount_q);
		end
		cfgv.r       = (fourier_q > R_MAX) ? R_MAX : fourier_q;
		cfgv.source  = source_q;
		cfgv.ambient = ambient_q;
	end

	hrfs_front #(.MAX_NODES(MAX_NODES)) u_front (
		.req        (req),
		.n_use      (n_use),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	hrfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hrfs_back #(.MAX_NODES(MAX_NODES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfgv      (cfgv),
		.n_use     (n_use),
		.clearing  (clearing),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule

/* rtl/core/hrfs_chk.sv */
// Port-level checker for the rod heat-step block, bound to the top level.
`timescale 1ns / 1ps
module hrfs_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [hrfs_pkg::TEMP_W-1:0]  rsp_temperature,
	input logic                         rsp_index_error,
	input logic [hrfs_pkg::STEPS_W-1:0] rsp_steps_done
);
	import hrfs_pkg::*;

	logic               req_acc;
	logic               rsp_acc;
	logic [3:0]         open_q;
	logic [STEPS_W-1:0] last_steps_q;

	assign req_acc = req_valid & req_ready;
	assign rsp_acc = rsp_valid & rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= '0;
			last_steps_q <= '0;
		end else begin
			open_q <= open_q + {3'b000, req_acc} - {3'b000, rsp_acc};
			if (rsp_acc) begin
				last_steps_q <= rsp_steps_done;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature)
		&& $stable(rsp_index_error) && $stable(rsp_steps_done))
		else $error("response dropped or changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_index_error |-> rsp_temperature == '0)
		else $error("index error with non-zero temperature");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> open_q != '0)
		else $error("response transaction without a request");

	a_steps_seq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> rsp_steps_done == '0 || rsp_steps_done == last_steps_q
		|| rsp_steps_done == last_steps_q + 32'd1)
		else $error("step count moved by more than one");

endmodule

bind heat_rod_ftcs_step_top hrfs_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_temperature (rsp.temperature),
	.rsp_index_error (rsp.index_error),
	.rsp_steps_done  (rsp.steps_done)
);

/* sim/rod_heat_checker.sv */
// Checker for the rod heat-step block: watches all channels, predicts each response and compares.
`timescale 1ns / 1ps
module rod_heat_checker #(
	parameter int unsigned MAX_NODES = hrfs_pkg::MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hrfs_req_if         req,
	hrfs_rsp_if         rsp,
	hrfs_cfg_if         cfg,
	output int unsigned mismatches,
	output int unsigned results_due,
	output int unsigned results_seen
);
	import hrfs_pkg::*;

	localparam longint      TEMP_TOP     = 64'h0000_0000_FFFF_FFFF;
	localparam int unsigned REPORT_LIMIT = 10;

	logic [TEMP_W-1:0]  rod_temp [MAX_NODES];
	logic [STEPS_W-1:0] steps_taken;
	logic [R_W-1:0]     fourier;
	logic [TEMP_W-1:0]  source_k;
	logic [TEMP_W-1:0]  ambient_k;
	logic [NC_W-1:0]    node_count;
	result_t            results_owed [$];

	function automatic int nodes_used();
		int n;
		n = node_count;
		if (n < NC_MIN) n = NC_MIN;
		if (n > MAX_NODES) n = MAX_NODES;
		return n;
	endfunction

	// Applies one transaction to the rod and returns the response it should produce.
	function automatic result_t rod_apply(input op_t op, input logic [IDX_W-1:0] idx);
		result_t           res;
		int                n;
		logic [R_W-1:0]    r_eff;
		longint            left;
		longint            mid;
		longint            right;
		longint            upd;
		logic [TEMP_W-1:0] nxt [MAX_NODES];
		res = '0;
		n = nodes_used();
		case (op)
			OP_INIT: begin
				for (int i = 0; i < MAX_NODES; i++) rod_temp[i] = ambient_k;
				rod_temp[0] = source_k;
				steps_taken = '0;
			end
			OP_STEP: begin
				r_eff = (fourier > R_MAX) ? R_MAX : fourier;
				for (int j = 1; j + 1 < n; j++) begin
					left  = rod_temp[j-1];
					mid   = rod_temp[j];
					right = rod_temp[j+1];
					// floor of r * laplacian in Q.16
					upd = mid + ((longint'(r_eff) * (right - 2 * mid + left)) >>> 16);
					if (upd < 0) upd = 0;
					else if (upd > TEMP_TOP) upd = TEMP_TOP;
					nxt[j] = upd[TEMP_W-1:0];
				end
				for (int j = 1; j + 1 < n; j++) rod_temp[j] = nxt[j];
				rod_temp[0] = source_k;
				rod_temp[n-1] = ambient_k;
				if (steps_taken != '1) steps_taken++;
			end
			OP_READ: begin
				if (idx < n) res.temperature = rod_temp[idx];
				else res.index_error = 1'b1;
			end
			OP_NOP: ;
			default: ;
		endcase
		res.steps_done = steps_taken;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t     got;
		result_t     want;
		int unsigned fails;
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) rod_temp[i] = '0;
			steps_taken = '0;
			fourier     = FOURIER_RST;
			source_k    = SOURCE_RST;
			ambient_k   = AMBIENT_RST;
			node_count  = NCOUNT_RST;
			results_owed.delete();
			mismatches   <= 0;
			results_due  <= 0;
			results_seen <= 0;
		end else begin
			fails = mismatches;
			// responses first: a request accepted on this edge cannot be answered on it
			if (rsp.valid && rsp.ready) begin
				got.temperature = rsp.temperature;
				got.index_error = rsp.index_error;
				got.steps_done  = rsp.steps_done;
				if (results_owed.size() == 0) begin
					if (fails < REPORT_LIMIT)
						$display({"%0t: response with nothing outstanding: ",
							"temperature %h index_error %0b steps_done %0d"},
							$realtime, got.temperature, got.index_error, got.steps_done);
					fails++;
				end else begin
					want = results_owed.pop_front();
					if (got.temperature !== want.temperature ||
							got.index_error !== want.index_error ||
							got.steps_done !== want.steps_done) begin
						if (fails < REPORT_LIMIT)
							$display({"%0t: mismatch: temperature exp %h got %h, ",
								"index_error exp %0b got %0b, steps_done exp %0d got %0d"},
								$realtime, want.temperature, got.temperature,
								want.index_error, got.index_error, want.steps_done,
								got.steps_done);
						fails++;
					end
					results_seen <= results_seen + 1;
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_FOURIER: fourier    = cfg.data[R_W-1:0];
					REG_SOURCE:  source_k   = cfg.data[TEMP_W-1:0];
					REG_AMBIENT: ambient_k  = cfg.data[TEMP_W-1:0];
					REG_NCOUNT:  node_count = cfg.data[NC_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				results_owed.push_back(rod_apply(op_t'(req.operation), req.node_index));
			mismatches  <= fails;
			results_due <= results_owed.size();
		end
	end

endmodule

/* sim/tb.sv */
// Testbench top for the rod heat-step block: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb;
	import hrfs_pkg::*;

	localparam int unsigned TOTAL_ITEMS     = 450;
	localparam int unsigned CYCLE_LIMIT     = 1_000_000;
	localparam int unsigned RSP_HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES   = MAX_NODES_DEF + 16;
	localparam int unsigned IDLE_PCT        = 37;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	hrfs_req_if req_if ();
	hrfs_rsp_if rsp_if ();
	hrfs_cfg_if cfg_if ();

	int unsigned mismatches;
	int unsigned results_due;
	int unsigned results_seen;

	heat_rod_ftcs_step_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	rod_heat_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_if),
		.rsp          (rsp_if),
		.cfg          (cfg_if),
		.mismatches   (mismatches),
		.results_due  (results_due),
		.results_seen (results_seen)
	);

	bit          req_idle_on = 1'b1;
	bit          rsp_idle_on = 1'b1;
	int unsigned hold_asked = 0;
	int unsigned nodes_now = NCOUNT_RST;
	int unsigned items_sent = 0;
	int unsigned ops_sent [4] = '{0, 0, 0, 0};
	int unsigned bad_reads = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count = 0;

	task automatic send_job(input op_t op, input logic [IDX_W-1:0] idx);
		while (req_idle_on && $urandom_range(99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.operation  <= op;
		req_if.node_index <= idx;
		do @(posedge clk); while (!req_if.ready);
		ops_sent[op]++;
		if (op == OP_READ && idx >= nodes_now) bad_reads++;
		items_sent++;
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	// Unused upper data bits carry noise; the block must drop them.
	task automatic set_regs(input logic [R_W-1:0] r, input logic [TEMP_W-1:0] src,
			input logic [TEMP_W-1:0] amb, input logic [NC_W-1:0] nc);
		wait_idle();
		write_reg(REG_FOURIER, {(CFG_DATA_W-R_W)'($urandom), r});
		write_reg(REG_NCOUNT, {(CFG_DATA_W-NC_W)'($urandom), nc});
		write_reg(REG_SOURCE, src);
		write_reg(REG_AMBIENT, amb);
		cfg_if.valid <= 1'b0;
		nodes_now = (nc < NC_MIN) ? NC_MIN : (nc > MAX_NODES_DEF) ? MAX_NODES_DEF : nc;
		settings_used++;
	endtask

	function automatic logic [TEMP_W-1:0] pick_temp();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return TEMP_W'($urandom);
			default: return {16'($urandom_range(250, 1000)), 16'($urandom)};
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_node(input bit outside);
		if (outside && nodes_now < MAX_NODES_DEF)
			return IDX_W'($urandom_range(MAX_NODES_DEF - 1, nodes_now));
		return IDX_W'($urandom_range(nodes_now - 1));
	endfunction

	initial begin : rsp_side
		int unsigned hold_done;
		hold_done = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_done) begin
				hold_done = hold_asked;
				rsp_if.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			rsp_if.ready <= !(rsp_idle_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d responses outstanding", cycle_count,
				results_due);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [R_W-1:0]    r;
		logic [NC_W-1:0]   nc;
		int unsigned       phase;
		int unsigned       pick;
		int unsigned       len;
		arst_n            <= 1'b0;
		req_if.valid      <= 1'b0;
		req_if.operation  <= OP_INIT;
		req_if.node_index <= '0;
		cfg_if.valid      <= 1'b0;
		cfg_if.index      <= REG_FOURIER;
		cfg_if.data       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset contents, step before init, spare code
		send_job(OP_READ, '0);
		send_job(OP_READ, '1);
		send_job(OP_STEP, IDX_W'($urandom));
		send_job(OP_READ, '0);
		send_job(OP_READ, 9'd500);
		send_job(OP_NOP, '1);
		send_job(OP_INIT, IDX_W'($urandom));
		send_job(OP_READ, 9'd1);
		send_job(OP_READ, 9'd501);
		send_job(OP_STEP, '0);
		send_job(OP_READ, 9'd499);
		// Fourier number above one half, node count below the minimum
		set_regs('1, '1, '0, '0);
		send_job(OP_STEP, '0);
		send_job(OP_READ, 9'd1);
		send_job(OP_READ, 9'd3);
		// zero Fourier number, node count above the maximum
		set_regs('0, '0, '1, '1);
		send_job(OP_INIT, '0);
		send_job(OP_STEP, '1);
		send_job(OP_READ, '1);
		send_job(OP_READ, '0);
		set_regs(R_MAX, '1, '0, NC_W'(MAX_NODES_DEF));
		send_job(OP_INIT, '1);
		send_job(OP_STEP, '0);
		send_job(OP_STEP, '0);
		send_job(OP_READ, 9'd1);
		send_job(OP_READ, 9'd510);
		send_job(OP_NOP, '0);

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			phase++;
			pick = $urandom_range(9);
			r = (pick == 0) ? '0 : (pick == 1) ? R_MAX : (pick == 2) ? R_W'($urandom) :
				R_W'($urandom_range(R_MAX));
			pick = $urandom_range(99);
			if (pick < 8) nc = NC_W'($urandom_range(2));
			else if (pick < 14) nc = NC_W'($urandom_range(1023, MAX_NODES_DEF + 1));
			else if (pick < 16) nc = NCOUNT_RST;
			else if (pick < 18) nc = NC_W'(MAX_NODES_DEF);
			else nc = NC_W'($urandom_range(40, NC_MIN));
			set_regs(r, pick_temp(), pick_temp(), nc);
			req_idle_on = !(phase == 4 || phase == 5);
			rsp_idle_on = req_idle_on;

			if (phase == 2) begin
				// stall the response side long enough for the job queue to back up
				hold_asked++;
				repeat (14) send_job(OP_READ, pick_node(1'b0));
			end

			if ($urandom_range(99) < 85) begin
				send_job(OP_INIT, IDX_W'($urandom));
				len = $urandom_range(30, 10);
				repeat (len) begin
					pick = $urandom_range(99);
					if (pick < 45) send_job(OP_STEP, IDX_W'($urandom));
					else if (pick < 85) send_job(OP_READ, pick_node(1'b0));
					else if (pick < 95) send_job(OP_READ, pick_node(1'b1));
					else send_job(OP_NOP, IDX_W'($urandom));
				end
			end else begin
				repeat ($urandom_range(12, 4))
					send_job(op_t'($urandom_range(3)), IDX_W'($urandom));
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display({"Run covered %0d init, %0d step, %0d read (%0d out of range), ",
			"%0d spare-code transactions"},
			ops_sent[OP_INIT], ops_sent[OP_STEP], ops_sent[OP_READ], bad_reads,
			ops_sent[OP_NOP]);
		$display({"over %0d register settings; %0d responses compared, ",
			"%0d mismatches, %0d outstanding"},
			settings_used, results_seen, mismatches, results_due);
		if (mismatches == 0 && results_due == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
